// ----- rtl/refcounted_page_bitmap_allocator_top_macros.svh -----
// Assertion macros for the allocator RTL.
// Used by rpba_dp; no other dependencies.
`ifndef REFCOUNTED_PAGE_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define REFCOUNTED_PAGE_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RPBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RPBA_ASSERT_AR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RPBA_ASSERT(lbl, prop, msg)
`define RPBA_ASSERT_AR(lbl, prop, msg)
`endif
`endif

// ----- rtl/rpba_pkg.sv -----
// Types and constants of the page allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rpba_pkg;

  localparam int unsigned NUM_PAGES = 4096;
  localparam int unsigned PAGE_W    = $clog2(NUM_PAGES);
  localparam int unsigned TOT_W     = PAGE_W + 1;
  localparam int unsigned REF_W     = 8;
  localparam int unsigned CFG_AW    = 3;
  localparam logic [REF_W-1:0] REF_MAX = '1;

  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    CMD_INIT      = 3'd0,
    CMD_ALLOC     = 3'd1,
    CMD_ALLOC_RUN = 3'd2,
    CMD_REF       = 3'd3,
    CMD_QUERY     = 3'd4,
    CMD_FREE      = 3'd5,
    CMD_FREE_RUN  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    RS_DONE      = 2'd0,
    RS_NOT_FOUND = 2'd1,
    RS_IGNORED   = 2'd2
  } res_status_e;

  typedef enum logic [2:0] {
    PH_CLEAR,
    PH_IDLE,
    PH_INIT,
    PH_SCAN,
    PH_FILL,
    PH_PEEK,
    PH_PEEKW,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] page;
    logic [12:0] count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] result_page;
    logic [7:0]  ref_count;
    logic [12:0] used_pages;
    logic [12:0] free_pages;
  } out_item_t;

  typedef struct packed {
    phase_e phase;
    logic   load;
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    cmd_e new_cmd;
    logic new_cnt_zero;
    logic sweep_last;
    logic scan_hit;
    logic scan_over;
    logic fill_last;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/rpba_ctrl.sv -----
// Sequencer of the page allocator: phase state machine.
// Depends on rpba_pkg; drives rpba_dp through ctl_t, reads sts_t.
`timescale 1ns / 1ps
module rpba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rpba_pkg::sts_t sts_i,
  output rpba_pkg::ctl_t ctl_o,
  output logic          in_stall_o
);
  import rpba_pkg::*;

  phase_e state_q, state_d;
  logic   in_fire;

  assign in_fire = in_valid_i && (state_q == PH_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      PH_CLEAR: if (sts_i.sweep_last) state_d = PH_IDLE;
      PH_IDLE: begin
        if (in_fire) begin
          unique case (sts_i.new_cmd) inside
            CMD_INIT:                state_d = PH_INIT;
            CMD_ALLOC, CMD_FREE_RUN: state_d = PH_SCAN;
            CMD_ALLOC_RUN:           state_d = sts_i.new_cnt_zero ? PH_DONE : PH_SCAN;
            CMD_REF, CMD_QUERY, CMD_FREE: state_d = PH_PEEK;
            default:                 state_d = PH_DONE;
          endcase
        end
      end
      PH_INIT: if (sts_i.sweep_last) state_d = PH_DONE;
      PH_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = (sts_i.cmd == CMD_ALLOC_RUN) ? PH_FILL : PH_DONE;
        end else if (sts_i.scan_over) begin
          state_d = (sts_i.cmd == CMD_FREE_RUN) ? PH_PEEK : PH_DONE;
        end
      end
      PH_FILL:  if (sts_i.fill_last) state_d = PH_DONE;
      PH_PEEK:  state_d = PH_PEEKW;
      PH_PEEKW: state_d = PH_DONE;
      PH_DONE:  if (!sts_i.out_busy) state_d = PH_IDLE;
      default:  state_d = PH_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.phase = state_q;
    ctl_o.load  = in_fire;
    in_stall_o  = (state_q != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/rpba_dp.sv -----
// Datapath of the page allocator: used bitmap and count memories, totals,
// config registers and result register. Depends on rpba_pkg and the macros header.
`timescale 1ns / 1ps
`include "refcounted_page_bitmap_allocator_top_macros.svh"
module rpba_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rpba_pkg::ctl_t            ctl_i,
  output rpba_pkg::sts_t            sts_o,
  input  rpba_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output rpba_pkg::out_item_t       out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rpba_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata
);
  import rpba_pkg::*;

  localparam logic [PAGE_W-1:0] TOP_PAGE  = PAGE_W'(NUM_PAGES - 1);
  localparam logic [TOT_W-1:0]  ALL_PAGES = TOT_W'(NUM_PAGES);

  // page memories
  logic             used_mem [NUM_PAGES];
  logic [REF_W-1:0] cnt_mem  [NUM_PAGES];
  logic             rd_used_q;
  logic [REF_W-1:0] rd_cnt_q;
  logic             we_used, we_cnt, wd_used;
  logic [PAGE_W-1:0] wa;
  logic [REF_W-1:0] wd_cnt;

  // control state
  logic [PAGE_W-1:0] cfg_first_q, cfg_first_d;
  logic [TOT_W-1:0]  cfg_limit_q, cfg_limit_d;
  logic [PAGE_W-1:0] eff_first_q, eff_first_d;
  logic [TOT_W-1:0]  eff_limit_q, eff_limit_d;
  logic [TOT_W-1:0]  managed_q, managed_d;
  logic [TOT_W-1:0]  alloc_q, alloc_d;
  logic [PAGE_W-1:0] hint_q, hint_d;
  logic [PAGE_W-1:0] ra_q, ra_d;
  logic [TOT_W-1:0]  left_q, left_d;
  logic              pv_q, pv_d;
  logic [TOT_W-1:0]  run_q, run_d;
  logic              changed_q, changed_d;
  logic              out_valid_q, out_valid_d;

  // payload
  cmd_e              cmd_q, cmd_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [TOT_W-1:0]  cnt_q, cnt_d;
  logic [PAGE_W-1:0] pa_q, pa_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [PAGE_W-1:0] res_page_q, res_page_d;
  logic [REF_W-1:0]  res_cnt_q, res_cnt_d;
  out_item_t         out_q, out_d;

  logic              cfg_wr;
  cmd_e              new_cmd;
  logic [TOT_W-1:0]  new_limit;
  logic [TOT_W:0]    run_end, run_lim, page_ext;
  logic [PAGE_W-1:0] nxt_ra, start_pg;
  logic              in_lo, free_ok;
  logic [REF_W-1:0]  new_cnt;
  logic [TOT_W-1:0]  free_tot;

  assign new_cmd = cmd_e'(in_data_i.command);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_FIRST: prdata = {{(32-PAGE_W){1'b0}}, cfg_first_q};
      REG_LIMIT: prdata = {{(32-TOT_W){1'b0}}, cfg_limit_q};
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    sts_o.cmd          = cmd_q;
    sts_o.new_cmd      = new_cmd;
    sts_o.new_cnt_zero = (in_data_i.count == '0);
    sts_o.sweep_last   = (ra_q == TOP_PAGE);
    sts_o.fill_last    = (left_q == TOT_W'(1));
    sts_o.scan_over    = (left_q == '0) && !pv_q;
    sts_o.out_busy     = out_valid_q && out_stall_i;
    case (cmd_q)
      CMD_ALLOC:     sts_o.scan_hit = pv_q && !rd_used_q;
      CMD_ALLOC_RUN: sts_o.scan_hit = pv_q && !rd_used_q && (run_q + TOT_W'(1) == cnt_q);
      default:       sts_o.scan_hit = 1'b0;
    endcase
  end

  assign free_tot = (alloc_q >= managed_q) ? '0 : managed_q - alloc_q;
  assign in_lo    = (page_q < eff_first_q);
  assign free_ok  = !in_lo && (TOT_W'(page_q) < eff_limit_q) && rd_used_q;

  always_comb begin
    new_limit = (cfg_limit_q == '0 || cfg_limit_q > ALL_PAGES) ? ALL_PAGES : cfg_limit_q;
    start_pg  = (hint_q < eff_first_q) ? eff_first_q : hint_q;
    page_ext  = (TOT_W+1)'(in_data_i.page);
    run_end   = page_ext + (TOT_W+1)'(in_data_i.count);
    run_lim   = (run_end > (TOT_W+1)'(eff_limit_q)) ? (TOT_W+1)'(eff_limit_q) : run_end;
    // single alloc wraps back to the first managed page
    if (cmd_q == CMD_ALLOC && ra_q == TOP_PAGE) nxt_ra = eff_first_q;
    else nxt_ra = ra_q + PAGE_W'(1);
  end

  always_comb begin
    cfg_first_d = cfg_first_q;
    cfg_limit_d = cfg_limit_q;
    eff_first_d = eff_first_q;
    eff_limit_d = eff_limit_q;
    managed_d   = managed_q;
    alloc_d     = alloc_q;
    hint_d      = hint_q;
    ra_d        = ra_q;
    left_d      = left_q;
    pv_d        = pv_q;
    run_d       = run_q;
    changed_d   = changed_q;
    cmd_d       = cmd_q;
    page_d      = page_q;
    cnt_d       = cnt_q;
    pa_d        = pa_q;
    res_status_d = res_status_q;
    res_page_d  = res_page_q;
    res_cnt_d   = res_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we_used     = 1'b0;
    we_cnt      = 1'b0;
    wa          = ra_q;
    wd_used     = 1'b0;
    wd_cnt      = '0;
    new_cnt     = rd_cnt_q;

    if (cfg_wr) begin
      unique case (paddr[2])
        REG_FIRST: cfg_first_d = pwdata[PAGE_W-1:0];
        REG_LIMIT: cfg_limit_d = pwdata[TOT_W-1:0];
        default:   cfg_first_d = cfg_first_q;
      endcase
    end

    case (ctl_i.phase)
      PH_CLEAR: begin
        we_used = 1'b1;
        we_cnt  = 1'b1;
        wd_used = 1'b1;
        ra_d    = ra_q + PAGE_W'(1);
      end
      PH_IDLE: begin
        if (ctl_i.load) begin
          cmd_d     = new_cmd;
          page_d    = in_data_i.page;
          cnt_d     = in_data_i.count;
          pv_d      = 1'b0;
          run_d     = '0;
          changed_d = 1'b0;
          ra_d      = in_data_i.page;
          left_d    = '0;
          res_cnt_d = '0;
          res_status_d = (new_cmd == CMD_INIT) ? RS_DONE : RS_IGNORED;
          case (new_cmd) inside
            CMD_INIT, CMD_ALLOC, CMD_ALLOC_RUN: res_page_d = '0;
            default:                            res_page_d = in_data_i.page;
          endcase
          case (new_cmd)
            CMD_INIT: begin
              eff_first_d = cfg_first_q;
              eff_limit_d = new_limit;
              managed_d   = (new_limit > TOT_W'(cfg_first_q)) ?
                            new_limit - TOT_W'(cfg_first_q) : '0;
              alloc_d     = '0;
              hint_d      = cfg_first_q;
              ra_d        = '0;
            end
            CMD_ALLOC: begin
              ra_d   = start_pg;
              left_d = ALL_PAGES - TOT_W'(eff_first_q);
            end
            CMD_ALLOC_RUN: begin
              ra_d   = eff_first_q;
              left_d = (eff_limit_q > TOT_W'(eff_first_q)) ?
                       eff_limit_q - TOT_W'(eff_first_q) : '0;
            end
            CMD_FREE_RUN: begin
              left_d = (run_lim > page_ext) ? TOT_W'(run_lim - page_ext) : '0;
            end
            default: ra_d = in_data_i.page;
          endcase
        end
      end
      PH_INIT: begin
        we_used = 1'b1;
        wd_used = !((ra_q >= eff_first_q) && (TOT_W'(ra_q) < eff_limit_q));
        ra_d    = ra_q + PAGE_W'(1);
      end
      PH_SCAN: begin
        // one read issued per cycle, its data checked the cycle after
        pv_d = (left_q != '0);
        pa_d = ra_q;
        if (left_q != '0) begin
          ra_d   = nxt_ra;
          left_d = left_q - TOT_W'(1);
        end
        if (pv_q) begin
          case (cmd_q)
            CMD_ALLOC: begin
              if (!rd_used_q) begin
                we_used = 1'b1;
                we_cnt  = 1'b1;
                wa      = pa_q;
                wd_used = 1'b1;
                wd_cnt  = REF_W'(1);
                alloc_d = alloc_q + TOT_W'(1);
                hint_d  = (pa_q == TOP_PAGE) ? '0 : pa_q + PAGE_W'(1);
                res_status_d = RS_DONE;
                res_page_d   = pa_q;
                res_cnt_d    = REF_W'(1);
              end
            end
            CMD_ALLOC_RUN: begin
              run_d = rd_used_q ? '0 : run_q + TOT_W'(1);
              if (sts_o.scan_hit) begin
                ra_d    = PAGE_W'(TOT_W'(pa_q) + TOT_W'(1) - cnt_q);
                left_d  = cnt_q;
                pv_d    = 1'b0;
                alloc_d = alloc_q + cnt_q;
                res_status_d = RS_DONE;
                res_page_d   = PAGE_W'(TOT_W'(pa_q) + TOT_W'(1) - cnt_q);
                res_cnt_d    = REF_W'(1);
              end
            end
            CMD_FREE_RUN: begin
              if (pa_q >= eff_first_q && rd_used_q) begin
                changed_d = 1'b1;
                we_cnt    = 1'b1;
                wa        = pa_q;
                if (rd_cnt_q > REF_W'(1)) begin
                  wd_cnt = rd_cnt_q - REF_W'(1);
                end else begin
                  we_used = 1'b1;
                  alloc_d = (alloc_q != '0) ? alloc_q - TOT_W'(1) : '0;
                end
              end
            end
            default: pv_d = 1'b0;
          endcase
        end
        if (sts_o.scan_over) begin
          if (cmd_q == CMD_FREE_RUN) begin
            ra_d = page_q;
          end else begin
            res_status_d = RS_NOT_FOUND;
            res_page_d   = '0;
            res_cnt_d    = '0;
          end
        end
      end
      PH_FILL: begin
        we_used = 1'b1;
        we_cnt  = 1'b1;
        wd_used = 1'b1;
        wd_cnt  = REF_W'(1);
        ra_d    = ra_q + PAGE_W'(1);
        left_d  = left_q - TOT_W'(1);
      end
      PH_PEEK: begin
        ra_d = page_q;
      end
      PH_PEEKW: begin
        wa         = page_q;
        res_page_d = page_q;
        case (cmd_q)
          CMD_REF: begin
            if (!in_lo && rd_used_q) begin
              new_cnt = (rd_cnt_q == REF_MAX) ? rd_cnt_q : rd_cnt_q + REF_W'(1);
              we_cnt  = 1'b1;
              wd_cnt  = new_cnt;
              res_status_d = RS_DONE;
            end else begin
              res_status_d = RS_IGNORED;
            end
          end
          CMD_QUERY: begin
            res_status_d = in_lo ? RS_IGNORED : RS_DONE;
          end
          CMD_FREE: begin
            if (free_ok) begin
              we_cnt = 1'b1;
              res_status_d = RS_DONE;
              if (rd_cnt_q > REF_W'(1)) begin
                new_cnt = rd_cnt_q - REF_W'(1);
              end else begin
                new_cnt = '0;
                we_used = 1'b1;
                alloc_d = (alloc_q != '0) ? alloc_q - TOT_W'(1) : '0;
              end
              wd_cnt = new_cnt;
            end else begin
              res_status_d = RS_IGNORED;
            end
          end
          default: begin
            res_status_d = changed_q ? RS_DONE : RS_IGNORED;
          end
        endcase
        res_cnt_d = in_lo ? '0 : new_cnt;
      end
      PH_DONE: begin
        if (!sts_o.out_busy) begin
          out_valid_d       = 1'b1;
          out_d.status      = res_status_q;
          out_d.result_page = res_page_q;
          out_d.ref_count   = res_cnt_q;
          out_d.used_pages  = alloc_q;
          out_d.free_pages  = free_tot;
        end
      end
      default: pv_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_used) used_mem[wa] <= wd_used;
    if (we_cnt)  cnt_mem[wa]  <= wd_cnt;
    rd_used_q <= used_mem[ra_q];
    rd_cnt_q  <= cnt_mem[ra_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_first_q <= '0;
      cfg_limit_q <= ALL_PAGES;
      eff_first_q <= '0;
      eff_limit_q <= '0;
      managed_q   <= '0;
      alloc_q     <= '0;
      hint_q      <= '0;
      ra_q        <= '0;
      left_q      <= '0;
      pv_q        <= 1'b0;
      run_q       <= '0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_first_q <= cfg_first_d;
      cfg_limit_q <= cfg_limit_d;
      eff_first_q <= eff_first_d;
      eff_limit_q <= eff_limit_d;
      managed_q   <= managed_d;
      alloc_q     <= alloc_d;
      hint_q      <= hint_d;
      ra_q        <= ra_d;
      left_q      <= left_d;
      pv_q        <= pv_d;
      run_q       <= run_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    page_q       <= page_d;
    cnt_q        <= cnt_d;
    pa_q         <= pa_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    res_cnt_q    <= res_cnt_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RPBA_ASSERT(a_alloc_bound, alloc_q <= ALL_PAGES, "allocated total above page count")
  `RPBA_ASSERT(a_fill_range, (ctl_i.phase == PH_FILL) |-> (ra_q >= eff_first_q && TOT_W'(ra_q) < eff_limit_q), "run fill outside managed range")
  `RPBA_ASSERT(a_init_zero, (ctl_i.phase == PH_INIT) |=> (alloc_q == '0), "allocated total not cleared by init")
  `RPBA_ASSERT_AR(a_no_load_clear, (ctl_i.phase == PH_CLEAR) |-> !ctl_i.load, "item taken during clearing pass")

endmodule

// ----- rtl/refcounted_page_bitmap_allocator_top.sv -----
// channel  | signals                         | dir
// in       | in_valid_i, in_stall_o, in_data_i  | item in: command, page, count
// out      | out_valid_o, out_stall_i, out_data_o | result: status, page, count, totals
// cfg      | psel/penable/pwrite/paddr/pwdata/prdata/pready | register access
// After reset a clearing pass walks all 4096 pages, one a cycle; no beat is taken then.
// Init: one page written per cycle. Ref, query, free: peek, peek-wait, then done.
// Alloc: pages scanned, then done on a hit or when nothing is found; contiguous alloc
// then writes each page of the run. Contiguous free: pages in range, then peek states.
// One read port on the page memories sets the pace.
// A finished result waits in the output register while the next beat is taken.
// Depends on rpba_pkg, rpba_ctrl, rpba_dp.
`timescale 1ns / 1ps
module refcounted_page_bitmap_allocator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rpba_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rpba_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpba_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rpba_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign pready = 1'b1;

  rpba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .in_stall_o (in_stall_o)
  );

  rpba_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

endmodule
